// ===== rtl/core/heat_stencil_5point_macros.svh =====
// Assertion macros shared by the heat stencil RTL.
// Stand-alone header, no dependencies.
`ifndef HEAT_STENCIL_5POINT_MACROS_SVH
`define HEAT_STENCIL_5POINT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HS5_ASSERT_IMP(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("heat stencil check failed");

// Next-cycle implication, disabled while reset is asserted
`define HS5_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("heat stencil sequence check failed");

`endif

// ===== rtl/core/hs5_pkg.sv =====
// Package for the 5-point heat stencil: sizes, codes and item types.
// No dependencies.
`default_nettype none

package hs5_pkg;

	// Line store depth and derived index widths
	localparam int MAX_WIDTH = 1024;
	localparam int IDX_W     = $clog2(MAX_WIDTH);
	localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

	// Item and register field widths
	localparam int TEMP_W     = 16;
	localparam int ROW_W      = 16;
	localparam int RWID_W     = 11;
	localparam int SPEED_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Datapath widths: sum of four neighbors, difference, product
	localparam int SUM_W  = TEMP_W + 2;
	localparam int DIFF_W = TEMP_W + 4;
	localparam int PROD_W = DIFF_W + SPEED_W + 1;
	localparam int FRAC_W = 8;

	// Register reset values
	localparam logic [RWID_W-1:0]  ROW_WIDTH_RST = RWID_W'(1024);
	localparam logic [ROW_W-1:0]   ROW_COUNT_RST = ROW_W'(1024);
	localparam logic [SPEED_W-1:0] SPEED_RST     = SPEED_W'(64);

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_WIDTH = 2'd0,
		REG_ROW_COUNT = 2'd1,
		REG_SPEED     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		op_t               op;
		logic [TEMP_W-1:0] cell_req;
	} in_item_t;

	typedef struct packed {
		logic [TEMP_W-1:0] new_temp;
		logic              frame_last;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/hs5_in_if.sv =====
// Input channel of the heat stencil: valid/ready with one cell or drain item.
// Depends on hs5_pkg.
`default_nettype none

interface hs5_in_if;
	logic               valid;
	logic               ready;
	hs5_pkg::in_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hs5_out_if.sv =====
// Result channel of the heat stencil: valid/ready with one updated cell.
// Depends on hs5_pkg.
`default_nettype none

interface hs5_out_if;
	logic                valid;
	logic                ready;
	hs5_pkg::out_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hs5_cfg_if.sv =====
// Configuration write channel of the heat stencil: register index and data.
// Depends on hs5_pkg.
`default_nettype none

interface hs5_cfg_if;
	logic                valid;
	logic                ready;
	hs5_pkg::cfg_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/heat_stencil_5point.sv =====
// Heat stencil top level: one 5-point Jacobi diffusion step over a raster stream.
// Result path: the item that completes a result loads the operand stage, then the result register.
// Throughput: one item per cycle while the result register can move; line store reads are prefetched.
// Reset: indices cleared, registers to 1024/1024/64; line stores are not cleared.
// Depends on hs5_pkg, hs5_in_if, hs5_out_if, hs5_cfg_if and the macros header.
`default_nettype none
`include "heat_stencil_5point_macros.svh"

module heat_stencil_5point (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hs5_in_if.sink     items,
	hs5_out_if.source  results,
	hs5_cfg_if.sink    cfg
);
	import hs5_pkg::*;

	// Control and configuration registers
	logic                run_q;
	logic [IDX_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [TEMP_W-1:0]   left_q;
	logic [RWID_W-1:0]   row_width_q;
	logic [ROW_W-1:0]    row_count_q;
	logic [SPEED_W-1:0]  speed_q;

	// Line stores and prefetched reads for the current column
	logic [TEMP_W-1:0]   mid_mem [MAX_WIDTH];
	logic [TEMP_W-1:0]   up_mem  [MAX_WIDTH];
	logic [TEMP_W-1:0]   mid_c_q;
	logic [TEMP_W-1:0]   mid_r_q;
	logic [TEMP_W-1:0]   up_q;

	// Operand stage
	logic                v_s1;
	logic [TEMP_W-1:0]   t_s1, b_s1, l_s1, r_s1, c_s1;
	logic                last_s1;

	// Result register
	logic                res_v_q;
	out_item_t           res_q;

	logic [CNT_W-1:0]    eff_w;
	logic [ROW_W-1:0]    eff_h;
	logic [CNT_W-1:0]    col_inc;
	logic                x_last;
	logic                fill_mode;
	logic                is_drain;
	logic                acc;
	logic                do_push;
	logic                do_drain;
	logic                produce;
	logic                out_free;
	logic                cfg_acc;
	logic                cfg_hit;
	logic [IDX_W-1:0]    col_d;
	logic [ROW_W-1:0]    row_d;
	logic [TEMP_W-1:0]   left_d;
	logic [IDX_W-1:0]    rd_r_addr;
	logic [TEMP_W-1:0]   t_sel, b_sel, l_sel, r_sel;

	// Effective geometry: zero counts as one, width clamps to the store depth
	always_comb begin
		if (row_width_q == '0) begin
			eff_w = CNT_W'(1);
		end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = CNT_W'(MAX_WIDTH);
		end else begin
			eff_w = CNT_W'(row_width_q);
		end
		eff_h = (row_count_q == '0) ? ROW_W'(1) : row_count_q;
	end

	assign col_inc   = CNT_W'(col_q) + CNT_W'(1);
	assign x_last    = col_inc >= eff_w;
	assign fill_mode = row_q < eff_h;

	// Handshakes; the operand stage moves whenever the result register frees
	assign out_free      = !res_v_q || results.ready;
	assign items.ready   = run_q && (out_free || !v_s1);
	assign cfg.ready     = run_q;
	assign results.valid = res_v_q;
	assign results.payload = res_q;

	assign acc      = items.valid && items.ready;
	assign is_drain = (items.payload.op == OP_DRAIN);
	assign do_push  = acc && !is_drain && fill_mode;
	assign do_drain = acc && is_drain && !fill_mode;
	assign produce  = (do_push && (row_q != '0)) || do_drain;
	assign cfg_acc  = cfg.valid && cfg.ready;

	// Register decode
	always_comb begin
		unique case (cfg.payload.index)
			REG_ROW_WIDTH, REG_ROW_COUNT, REG_SPEED: cfg_hit = cfg_acc;
			default:                                 cfg_hit = 1'b0;
		endcase
	end

	// Next column, row and left neighbor; a register write restarts the frame
	always_comb begin
		col_d  = col_q;
		row_d  = row_q;
		left_d = left_q;
		if (cfg_hit) begin
			col_d  = '0;
			row_d  = '0;
			left_d = '0;
		end else if (do_push) begin
			if (x_last) begin
				col_d = '0;
				row_d = row_q + ROW_W'(1);
			end else begin
				col_d = col_inc[IDX_W-1:0];
			end
			if (row_q != '0) begin
				left_d = mid_c_q;
			end
		end else if (do_drain) begin
			if (x_last) begin
				col_d  = '0;
				row_d  = '0;
				left_d = '0;
			end else begin
				col_d  = col_inc[IDX_W-1:0];
				left_d = mid_c_q;
			end
		end
	end

	assign rd_r_addr = col_d + IDX_W'(1);

	// Neighbor selection; off-grid neighbors take the center value
	always_comb begin
		if (is_drain ? (eff_h >= ROW_W'(2)) : (row_q >= ROW_W'(2))) begin
			t_sel = up_q;
		end else begin
			t_sel = mid_c_q;
		end
		b_sel = is_drain ? mid_c_q : items.payload.cell_req;
		l_sel = (col_q == '0) ? mid_c_q : left_q;
		r_sel = x_last ? mid_c_q : mid_r_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			left_q      <= '0;
			row_width_q <= ROW_WIDTH_RST;
			row_count_q <= ROW_COUNT_RST;
			speed_q     <= SPEED_RST;
			v_s1        <= 1'b0;
			res_v_q     <= 1'b0;
		end else begin
			run_q  <= 1'b1;
			col_q  <= col_d;
			row_q  <= row_d;
			left_q <= left_d;
			if (cfg_acc) begin
				unique case (cfg.payload.index)
					REG_ROW_WIDTH: row_width_q <= cfg.payload.data[RWID_W-1:0];
					REG_ROW_COUNT: row_count_q <= cfg.payload.data[ROW_W-1:0];
					REG_SPEED:     speed_q     <= cfg.payload.data[SPEED_W-1:0];
					default:       ;
				endcase
			end
			if (acc) begin
				v_s1 <= produce;
			end else if (out_free) begin
				v_s1 <= 1'b0;
			end
			if (out_free) begin
				res_v_q <= v_s1;
			end
		end
	end

	// Line stores: write on push, read the next column with same-cycle forwarding
	always_ff @(posedge clk) begin
		if (do_push) begin
			mid_mem[col_q] <= items.payload.cell_req;
			up_mem[col_q]  <= mid_c_q;
		end
		if (do_push && (col_d == col_q)) begin
			mid_c_q <= items.payload.cell_req;
			up_q    <= mid_c_q;
		end else begin
			mid_c_q <= mid_mem[col_d];
			up_q    <= up_mem[col_d];
		end
		if (do_push && (rd_r_addr == col_q)) begin
			mid_r_q <= items.payload.cell_req;
		end else begin
			mid_r_q <= mid_mem[rd_r_addr];
		end
	end

	// Operand stage
	always_ff @(posedge clk) begin
		if (produce) begin
			t_s1    <= t_sel;
			b_s1    <= b_sel;
			l_s1    <= l_sel;
			r_s1    <= r_sel;
			c_s1    <= mid_c_q;
			last_s1 <= do_drain && x_last;
		end
	end

	// Stencil: c + floor((speed*(t+b+l+r-4c) + 128) / 256), saturated
	logic [SUM_W-1:0]          nb_sum;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_rnd;
	logic signed [DIFF_W-1:0]  step;
	logic signed [DIFF_W-1:0]  upd;
	logic [TEMP_W-1:0]         sat;

	always_comb begin
		nb_sum   = SUM_W'(t_s1) + SUM_W'(b_s1) + SUM_W'(l_s1) + SUM_W'(r_s1);
		diff     = $signed(DIFF_W'(nb_sum)) - $signed(DIFF_W'({c_s1, 2'b00}));
		prod     = $signed({1'b0, speed_q}) * diff;
		prod_rnd = prod + PROD_W'(128);
		step     = prod_rnd[PROD_W-1:FRAC_W];
		upd      = $signed(DIFF_W'(c_s1)) + step;
		if (upd[DIFF_W-1]) begin
			sat = '0;
		end else if (upd[DIFF_W-2:TEMP_W] != '0) begin
			sat = '1;
		end else begin
			sat = upd[TEMP_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			res_q.new_temp   <= sat;
			res_q.frame_last <= last_s1;
		end
	end

	// Checks
	`HS5_ASSERT_IMP(a_col_range, clk, arst_n, run_q, CNT_W'(col_q) < eff_w)
	`HS5_ASSERT_IMP(a_row_range, clk, arst_n, run_q, row_q <= eff_h)
	`HS5_ASSERT_NEXT(a_frame_restart, clk, arst_n, do_drain && x_last && !cfg_hit, (row_q == '0) && (col_q == '0))
	`HS5_ASSERT_NEXT(a_stage_hold, clk, arst_n, v_s1 && !out_free, v_s1 && res_v_q)

endmodule

`default_nettype wire

// ===== dv/tb_heat_stencil_5point.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for heat_stencil_5point: directed and random raster streams,
// predicted cell by cell by a scoreboard class and checked on the result channel.
// Depends on hs5_pkg, the three channel interfaces and the heat_stencil_5point RTL.

module tb_heat_stencil_5point;
	import hs5_pkg::*;

	localparam int RANDOM_ITEMS  = 250;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_SLACK     = 20;
	localparam int STALL_LIMIT   = 2000;
	// Register index past the end of the map: the block ignores writes to it
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

	// Predicts the updated temperature of every cell and checks results in order
	class stencil_scoreboard;
		logic [RWID_W-1:0]  row_width;
		logic [ROW_W-1:0]   row_count;
		logic [SPEED_W-1:0] speed;
		logic [TEMP_W-1:0]  upper_row [MAX_WIDTH];
		logic [TEMP_W-1:0]  middle_row [MAX_WIDTH];
		int unsigned        col, row, drain_col;
		logic [TEMP_W-1:0]  left_cell;
		out_item_t          expected_cells [$];
		int                 errors;

		function new();
			row_width = ROW_WIDTH_RST;
			row_count = ROW_COUNT_RST;
			speed     = SPEED_RST;
			errors    = 0;
			foreach (upper_row[i]) begin
				upper_row[i]  = '0;
				middle_row[i] = '0;
			end
			restart();
		endfunction

		function void restart();
			col       = 0;
			row       = 0;
			drain_col = 0;
			left_cell = '0;
		endfunction

		function int unsigned active_width();
			if (row_width == 0) return 1;
			if (row_width > MAX_WIDTH) return MAX_WIDTH;
			return row_width;
		endfunction

		function int unsigned active_rows();
			return (row_count == 0) ? 1 : row_count;
		endfunction

		function int pending();
			return expected_cells.size();
		endfunction

		// c + speed*(t+b+l+r-4c)/256, step rounded to nearest with ties up, saturated
		function logic [TEMP_W-1:0] diffuse(input logic [TEMP_W-1:0] t, b, l, r, c);
			longint lap, step, v;
			lap  = longint'(t) + longint'(b) + longint'(l) + longint'(r) - 4 * longint'(c);
			step = (longint'(speed) * lap + 128) >>> FRAC_W;
			v    = longint'(c) + step;
			if (v < 0) v = 0;
			else if (v > (1 << TEMP_W) - 1) v = (1 << TEMP_W) - 1;
			return v[TEMP_W-1:0];
		endfunction

		// Any register write restarts the frame; the spare index does nothing
		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ROW_WIDTH: row_width = data[RWID_W-1:0];
				REG_ROW_COUNT: row_count = data[ROW_W-1:0];
				REG_SPEED:     speed     = data[SPEED_W-1:0];
				default:       return;
			endcase
			restart();
		endfunction

		// Returns 1 when the item does something, 0 when the block ignores it
		function bit note_item(input in_item_t it);
			int unsigned w, h, x;
			logic [TEMP_W-1:0] c, t, l, r;
			out_item_t res;
			w = active_width();
			h = active_rows();
			if (it.op == OP_PUSH) begin
				x = col;
				if (row >= h || x >= w) return 0;
				// result for the row above the incoming one
				if (row >= 1) begin
					c = middle_row[x];
					t = (row >= 2) ? upper_row[x] : c;
					l = (x == 0) ? c : left_cell;
					r = (x + 1 < w) ? middle_row[x + 1] : c;
					res.new_temp   = diffuse(t, it.cell_req, l, r, c);
					res.frame_last = 1'b0;
					expected_cells.push_back(res);
					left_cell = c;
				end
				upper_row[x]  = middle_row[x];
				middle_row[x] = it.cell_req;
				if (x + 1 >= w) begin
					col = 0;
					row++;
				end else begin
					col = x + 1;
				end
			end else begin
				x = drain_col;
				if (row < h || x >= w) return 0;
				// last row: bottom neighbor is the cell itself
				c = middle_row[x];
				t = (h >= 2) ? upper_row[x] : c;
				l = (x == 0) ? c : left_cell;
				r = (x + 1 < w) ? middle_row[x + 1] : c;
				res.new_temp = diffuse(t, c, l, r, c);
				left_cell = c;
				if (x + 1 >= w) begin
					res.frame_last = 1'b1;
					restart();
				end else begin
					res.frame_last = 1'b0;
					drain_col = x + 1;
				end
				expected_cells.push_back(res);
			end
			return 1;
		endfunction

		function void check_result(input out_item_t got);
			out_item_t exp;
			if (expected_cells.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h/%b",
					$time, got.new_temp, got.frame_last);
				errors++;
				return;
			end
			exp = expected_cells.pop_front();
			if (got.new_temp !== exp.new_temp) begin
				$display("%0t: new_temp mismatch, expected %h, actual %h",
					$time, exp.new_temp, got.new_temp);
				errors++;
			end
			if (got.frame_last !== exp.frame_last) begin
				$display("%0t: frame_last mismatch, expected %b, actual %b",
					$time, exp.frame_last, got.frame_last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   useful_items;
	stencil_scoreboard sb;

	hs5_in_if  item_ch ();
	hs5_out_if result_ch ();
	hs5_cfg_if cfg_ch ();

	heat_stencil_5point dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Present one item at the falling edge, hold it until accepted
	task automatic send_item(input in_item_t it);
		int gap;
		if (!calm && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 11);
			repeat (gap) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		item_ch.valid   <= 1'b1;
		item_ch.payload <= it;
		do @(posedge clk); while (!item_ch.ready);
		if (sb.note_item(it)) useful_items++;
	endtask

	task automatic push_cell(input logic [TEMP_W-1:0] cell_val);
		in_item_t it;
		it.op       = OP_PUSH;
		it.cell_req = cell_val;
		send_item(it);
	endtask

	task automatic drain_one();
		in_item_t it;
		it.op       = OP_DRAIN;
		it.cell_req = TEMP_W'($urandom);
		send_item(it);
	endtask

	// Stop sending until every predicted result has come back
	task automatic hold_until_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Also covers items still in flight that produce no result
	task automatic wait_idle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_item_t wr;
		wr.index = idx;
		wr.data  = data;
		@(negedge clk);
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= wr;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Unused upper data bits are randomized
	task automatic configure(input int width, input int rows, input int spd);
		logic [CFG_DATA_W-1:0] data;
		wait_idle();
		data = CFG_DATA_W'($urandom);
		data[RWID_W-1:0] = width[RWID_W-1:0];
		write_reg(REG_ROW_WIDTH, data);
		write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
		data = CFG_DATA_W'($urandom);
		data[SPEED_W-1:0] = spd[SPEED_W-1:0];
		write_reg(REG_SPEED, data);
	endtask

	function automatic logic [TEMP_W-1:0] random_cell();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			default: return TEMP_W'($urandom);
		endcase
	endfunction

	// Result sink with random stall bursts
	initial begin
		int stall_left;
		stall_left      = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && stall_left == 0 && $urandom_range(0, 11) == 0)
				stall_left = $urandom_range(1, 11);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Result checking
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.payload);
	end

	// Watchdog: ends the run when no channel moves an item for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// Stimulus
	initial begin
		int width, rows, spd, w, h, n_push, n_drain, pause_at, phase;
		bit full;
		sb              = new();
		calm            = 1'b0;
		useful_items    = 0;
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.payload  = '0;
		arst_n          = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: first-row cells give nothing, a drain is ignored
		push_cell(16'h0000);
		push_cell(16'hFFFF);
		drain_one();

		// 3x2 frame with extreme cells, push ignored while drain pending,
		// drain ignored once the frame has restarted
		configure(3, 2, 64);
		push_cell(16'h0000);
		push_cell(16'hFFFF);
		push_cell(16'h8000);
		push_cell(16'hFFFF);
		push_cell(16'h0000);
		push_cell(16'h1234);
		push_cell(16'hFFFF);
		repeat (3) drain_one();
		drain_one();

		// Single-row frame at top speed
		configure(2, 1, 127);
		push_cell(16'h0000);
		push_cell(16'hFFFF);
		repeat (2) drain_one();

		// Write to the spare index mid-frame must not restart the frame
		configure(2, 3, 100);
		push_cell(16'hFFFF);
		push_cell(16'h0001);
		wait_idle();
		write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
		push_cell(16'h0000);
		push_cell(16'hFFFF);
		push_cell(16'h7FFF);
		push_cell(16'h0000);
		repeat (2) drain_one();

		// Widest row, width field above the store depth; the next write cuts the drain short
		configure(2047, 1, $urandom_range(0, 127));
		repeat (MAX_WIDTH) push_cell(random_cell());
		repeat (8) drain_one();

		// Random frames: mostly complete, some cut short, with ignored items mixed in
		useful_items = 0;
		phase = 0;
		while (useful_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0: width = 0;
				1: width = 1;
				2: width = $urandom_range(9, 40);
				default: width = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 19))
				0: rows = 0;
				1: rows = 1;
				2: rows = 65535;
				3: rows = $urandom_range(7, 300);
				default: rows = $urandom_range(2, 6);
			endcase
			case ($urandom_range(0, 9))
				0: spd = 0;
				1: spd = 127;
				2: spd = 64;
				3: spd = $urandom_range(65, 127);
				default: spd = $urandom_range(0, 64);
			endcase
			configure(width, rows, spd);
			w = (width == 0) ? 1 : width;
			h = (rows == 0) ? 1 : rows;
			full = (h <= 8) && ($urandom_range(0, 7) != 0);
			n_push = full ? h * w : $urandom_range(0, ((h > 8) ? 8 : h) * w);
			pause_at = (phase == 0 || $urandom_range(0, 9) == 0) ? n_push / 2 : -1;

			for (int k = 0; k < n_push; k++) begin
				if (k == pause_at) hold_until_drained();
				if (useful_items >= RANDOM_ITEMS * 4 / 5) calm = 1'b1;
				// drain before the last row is in: ignored
				if ($urandom_range(0, 15) == 0) drain_one();
				push_cell(random_cell());
			end
			if (full) begin
				n_drain = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w - 1) : w;
				for (int k = 0; k < n_drain; k++) begin
					// push while the last row drains: ignored
					if ($urandom_range(0, 15) == 0) push_cell(random_cell());
					drain_one();
				end
			end
			phase++;
			if (useful_items >= RANDOM_ITEMS * 4 / 5) calm = 1'b1;
		end

		hold_until_drained();
		repeat (END_SLACK) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
